### design/gtnsk_pkg.sv
package gtnsk_pkg;

    // table sizes
    localparam int GROUP_SLOTS = 8;
    localparam int GROUP_DEPTH = 16;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // response error codes
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_NO_SLOT  = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    // width of the keep limit register
    localparam int KEEP_W = 5;

    // one request
    typedef struct packed {
        logic               opcode;
        logic [15:0]        group_key;
        logic signed [31:0] sort_value;
        logic               max_mode;
        logic               limited_kind;
        logic [15:0]        item_tag;
        logic [2:0]         read_group;
        logic [3:0]         read_pos;
    } req_t;

    // one response
    typedef struct packed {
        logic               evicted_valid;
        logic [15:0]        evicted_tag;
        logic [2:0]         group_slot;
        logic [4:0]         insert_pos;
        logic [1:0]         error_flag;
        logic               read_valid;
        logic signed [31:0] read_value;
        logic [15:0]        read_tag;
        logic [4:0]         read_count;
    } rsp_t;

    // true if a is strictly more critical than b
    function automatic logic beats(
        input logic signed [31:0] a,
        input logic signed [31:0] b,
        input logic               max_sel
    );
        beats = max_sel ? (a > b) : (a < b);
    endfunction

endpackage

### design/gtnsk_ram.sv
module gtnsk_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/grouped_top_n_sorted_keeper_top.sv
// Grouped sorted keeper: holds up to GROUP_SLOTS groups of (value, tag) entries, one group
// per 16-bit key, opened in order of first appearance and never closed, each kept most
// critical first. An insert request scans the group keys one slot per cycle, then walks the
// group's entries one per cycle to find the place of the new item, then shifts the entries
// between that place and the dropped position one per cycle through the single read and
// single write port of the entry memory. An insert into an existing group passes through
// ST_SCAN, ST_FIND and ST_PLAN, then ST_EVICT when a stored entry is dropped, then ST_MOVE,
// and ends in ST_DONE; when the item itself falls out, ST_PLAN goes straight to ST_DONE.
// Opening a new group or a rejection goes from the key scan straight to ST_DONE, and a read
// request passes through ST_READ and ST_DONE. The next request is taken in ST_IDLE once
// ST_DONE has raised the response. The block takes one request at a time (req_stall is high
// while it works) and may accept the next request while the previous response still waits
// on rsp_stall. keep_limit resets to 1 and is written through the cfg port, which is always
// ready.
module grouped_top_n_sorted_keeper_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  gtnsk_pkg::req_t                       req_data,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output gtnsk_pkg::rsp_t                       rsp_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gtnsk_pkg::KEEP_W-1:0]          cfg_data
);

    localparam int GROUP_SLOTS = gtnsk_pkg::GROUP_SLOTS;
    localparam int GROUP_DEPTH = gtnsk_pkg::GROUP_DEPTH;
    localparam int GW  = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
    localparam int SW  = $clog2(GROUP_SLOTS + 1);
    localparam int FW  = $clog2(GROUP_DEPTH + 1);
    localparam int NW  = $clog2(GROUP_DEPTH + 2);
    localparam int CW  = (NW > gtnsk_pkg::KEEP_W) ? NW : gtnsk_pkg::KEEP_W;
    localparam int ENT = GROUP_SLOTS * GROUP_DEPTH;
    localparam int AW  = (ENT > 1) ? $clog2(ENT) : 1;
    localparam int TW  = 16 + FW;
    localparam int EW  = 48;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SCAN  = 8'b0000_0010,
        ST_FIND  = 8'b0000_0100,
        ST_PLAN  = 8'b0000_1000,
        ST_EVICT = 8'b0001_0000,
        ST_MOVE  = 8'b0010_0000,
        ST_READ  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t                       state_reg, state_next;
    logic [gtnsk_pkg::KEEP_W-1:0] keep_reg, keep_next;
    logic [SW-1:0]                cnt_reg, cnt_next;
    logic                         rsp_valid_reg, rsp_valid_next;
    gtnsk_pkg::rsp_t              rsp_data_reg, rsp_data_next;
    gtnsk_pkg::req_t              req_reg, req_next;
    gtnsk_pkg::rsp_t              res_reg, res_next;
    logic [SW-1:0]                sidx_reg, sidx_next;
    logic [GW-1:0]                grp_reg, grp_next;
    logic [FW-1:0]                fill_reg, fill_next;
    logic [NW-1:0]                idx_reg, idx_next;
    logic [NW-1:0]                pos_reg, pos_next;
    logic [NW-1:0]                ipos_reg, ipos_next;
    logic                         asc_reg, asc_next;

    // memory ports
    logic                         tbl_we;
    logic [GW-1:0]                tbl_waddr;
    logic [TW-1:0]                tbl_wdata;
    logic [GW-1:0]                tbl_raddr;
    logic [TW-1:0]                tbl_rdata;
    logic                         ent_we;
    logic [AW-1:0]                ent_waddr;
    logic [EW-1:0]                ent_wdata;
    logic [AW-1:0]                ent_raddr;
    logic [EW-1:0]                ent_rdata;

    // placement plan
    logic [NW-1:0]                plan_n;
    logic [gtnsk_pkg::KEEP_W-1:0] plan_k;
    logic                         plan_cut;
    logic                         plan_err;
    logic [NW-1:0]                plan_drop;
    logic [NW-1:0]                plan_move_next;

    // flat entry address of a position within a group
    function automatic logic [AW-1:0] ent_addr(input logic [GW-1:0] g, input logic [NW-1:0] j);
        ent_addr = AW'(g) * AW'(GROUP_DEPTH) + AW'(j);
    endfunction

    // group table: key and fill per slot
    gtnsk_ram #(
        .WIDTH (TW),
        .DEPTH (GROUP_SLOTS)
    ) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // entry store: value and tag per group position
    gtnsk_ram #(
        .WIDTH (EW),
        .DEPTH (ENT)
    ) u_ent (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
    assign cfg_ready = 1'b1;

    // drop position after the item is placed
    always_comb
    begin
        plan_n   = NW'(fill_reg) + NW'(1);
        plan_k   = (keep_reg == '0) ? gtnsk_pkg::KEEP_W'(1) : keep_reg;
        plan_cut = req_reg.limited_kind && (CW'(plan_n) > CW'(plan_k));
        plan_err = 1'b0;
        priority if (plan_cut)
        begin
            plan_drop = NW'(plan_k);
        end
        else if (plan_n > NW'(GROUP_DEPTH))
        begin
            plan_drop = NW'(GROUP_DEPTH);
            plan_err  = 1'b1;
        end
        else
        begin
            plan_drop = plan_n;
        end
        plan_move_next = (plan_drop > pos_reg) ? plan_drop - NW'(1) : plan_drop;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        keep_next      = keep_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        sidx_next      = sidx_reg;
        grp_next       = grp_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        ipos_next      = ipos_reg;
        asc_next       = asc_reg;

        tbl_we    = 1'b0;
        tbl_waddr = grp_reg;
        tbl_wdata = {req_reg.group_key, fill_reg};
        tbl_raddr = '0;
        ent_we    = 1'b0;
        ent_waddr = ent_addr(grp_reg, idx_reg);
        ent_wdata = {req_reg.sort_value, req_reg.item_tag};
        ent_raddr = ent_addr(grp_reg, idx_reg);

        if (cfg_valid)
        begin
            keep_next = cfg_data;
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req_data;
                    if (req_data.opcode == gtnsk_pkg::OP_READ)
                    begin
                        tbl_raddr  = GW'(req_data.read_group);
                        ent_raddr  = ent_addr(GW'(req_data.read_group), NW'(req_data.read_pos));
                        state_next = ST_READ;
                    end
                    else
                    begin
                        tbl_raddr  = '0;
                        sidx_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_READ:
            begin
                res_next = '0;
                if (32'(req_reg.read_group) < 32'(cnt_reg))
                begin
                    res_next.read_count = 5'(tbl_rdata[FW-1:0]);
                    if (32'(req_reg.read_pos) < 32'(tbl_rdata[FW-1:0]))
                    begin
                        res_next.read_valid = 1'b1;
                        res_next.read_value = ent_rdata[EW-1:16];
                        res_next.read_tag   = ent_rdata[15:0];
                    end
                end
                state_next = ST_DONE;
            end

            // one slot key compared per cycle, next slot read ahead
            ST_SCAN:
            begin
                tbl_raddr = GW'(sidx_reg + SW'(1));
                priority if (sidx_reg == cnt_reg)
                begin
                    res_next = '0;
                    if (cnt_reg == SW'(GROUP_SLOTS))
                    begin
                        res_next.error_flag = gtnsk_pkg::ERR_NO_SLOT;
                        res_next.insert_pos = 5'(GROUP_DEPTH);
                    end
                    else
                    begin
                        // open a new group holding just this item
                        tbl_we              = 1'b1;
                        tbl_waddr           = GW'(cnt_reg);
                        tbl_wdata           = {req_reg.group_key, FW'(1)};
                        ent_we              = 1'b1;
                        ent_waddr           = ent_addr(GW'(cnt_reg), '0);
                        cnt_next            = cnt_reg + SW'(1);
                        res_next.group_slot = 3'(cnt_reg);
                    end
                    state_next = ST_DONE;
                end
                else if (tbl_rdata[TW-1:FW] == req_reg.group_key)
                begin
                    grp_next   = GW'(sidx_reg);
                    fill_next  = tbl_rdata[FW-1:0];
                    idx_next   = '0;
                    ent_raddr  = ent_addr(GW'(sidx_reg), '0);
                    state_next = ST_FIND;
                end
                else
                begin
                    sidx_next = sidx_reg + SW'(1);
                end
            end

            // one stored entry compared per cycle
            ST_FIND:
            begin
                ent_raddr = ent_addr(grp_reg, idx_reg + NW'(1));
                priority if (idx_reg == NW'(fill_reg))
                begin
                    pos_next   = idx_reg;
                    state_next = ST_PLAN;
                end
                else if (gtnsk_pkg::beats(req_reg.sort_value, ent_rdata[EW-1:16],
                                          req_reg.max_mode))
                begin
                    pos_next   = idx_reg;
                    state_next = ST_PLAN;
                end
                else
                begin
                    idx_next = idx_reg + NW'(1);
                end
            end

            // settle drop position, new fill and shift direction
            ST_PLAN:
            begin
                res_next            = '0;
                res_next.group_slot = 3'(grp_reg);
                res_next.insert_pos = 5'(pos_reg);
                res_next.error_flag = plan_err ? gtnsk_pkg::ERR_OVERFLOW : gtnsk_pkg::ERR_OK;
                tbl_we              = 1'b1;
                tbl_waddr           = grp_reg;
                tbl_wdata           = {req_reg.group_key,
                                       (plan_drop == plan_n) ? FW'(plan_n) : fill_reg};
                fill_next           = (plan_drop == plan_n) ? FW'(plan_n) : fill_reg;
                idx_next            = plan_move_next;
                priority if (plan_drop == pos_reg)
                begin
                    // the item itself falls out
                    res_next.evicted_valid = 1'b1;
                    res_next.evicted_tag   = req_reg.item_tag;
                    state_next             = ST_DONE;
                end
                else if (plan_drop > pos_reg)
                begin
                    asc_next  = 1'b0;
                    ipos_next = pos_reg;
                    if (plan_drop == plan_n)
                    begin
                        ent_raddr  = ent_addr(grp_reg, plan_move_next - NW'(1));
                        state_next = ST_MOVE;
                    end
                    else
                    begin
                        ent_raddr  = ent_addr(grp_reg, plan_move_next);
                        state_next = ST_EVICT;
                    end
                end
                else
                begin
                    asc_next   = 1'b1;
                    ipos_next  = pos_reg - NW'(1);
                    ent_raddr  = ent_addr(grp_reg, plan_move_next);
                    state_next = ST_EVICT;
                end
            end

            ST_EVICT:
            begin
                res_next.evicted_valid = 1'b1;
                res_next.evicted_tag   = ent_rdata[15:0];
                ent_raddr  = ent_addr(grp_reg, asc_reg ? idx_reg + NW'(1) : idx_reg - NW'(1));
                state_next = ST_MOVE;
            end

            // one entry shifted per cycle, item written last
            ST_MOVE:
            begin
                ent_we    = 1'b1;
                ent_waddr = ent_addr(grp_reg, idx_reg);
                if (idx_reg == ipos_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ent_wdata = ent_rdata;
                    if (asc_reg)
                    begin
                        idx_next  = idx_reg + NW'(1);
                        ent_raddr = ent_addr(grp_reg, idx_reg + NW'(2));
                    end
                    else
                    begin
                        idx_next  = idx_reg - NW'(1);
                        ent_raddr = ent_addr(grp_reg, idx_reg - NW'(2));
                    end
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            keep_reg      <= gtnsk_pkg::KEEP_W'(1);
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            keep_reg      <= keep_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
        req_reg      <= req_next;
        res_reg      <= res_next;
        sidx_reg     <= sidx_next;
        grp_reg      <= grp_next;
        fill_reg     <= fill_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        ipos_reg     <= ipos_next;
        asc_reg      <= asc_next;
    end

    // group count stays within the table
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= SW'(GROUP_SLOTS))
        else $error("group count beyond table size");

    // groups are only ever opened one at a time
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> (cnt_reg == $past(cnt_reg) + SW'(1)))
        else $error("group count moved by other than one");

    // no stray eviction tag
    a_evict_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.evicted_valid) |-> (rsp_data.evicted_tag == '0))
        else $error("eviction tag without eviction");

    // rejected insert reports no place and no eviction
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.error_flag == gtnsk_pkg::ERR_NO_SLOT)
        |-> (rsp_data.insert_pos == 5'(GROUP_DEPTH) && !rsp_data.evicted_valid))
        else $error("rejected insert with placement");

endmodule
